// ----- rtl/core/sycb_pkg.sv -----
// ============================================================================
// sycb_pkg: shared types and constants of the scaled YCoCg to BGRA converter
// Item layouts, pipeline word and channel codes used by every stage.
// ============================================================================
`default_nettype none

package sycb_pkg;

    // Channel slots inside the pipeline word.
    localparam int NUM_CH   = 3;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // The numerator 16*k + 513*d is never negative and stays below 2^18.
    localparam int REM_W = 18;
    // The quotient numerator / (2*d) never exceeds 512.
    localparam int QUO_W = 10;
    // The divisor 2*d lies in 16..526.
    localparam int DIV_W = 10;
    // Width that holds the divisor at its largest shift.
    localparam int CMP_W = DIV_W + QUO_W;
    // Bias of 256 added to every quotient to keep the numerator positive.
    localparam int BIAS  = 256;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [7:0] co_byte;
        logic [7:0] cg_byte;
        logic [7:0] chroma_scale;
        logic [7:0] luma;
        logic [7:0] alpha_in;
        logic       last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha_out;
        logic       last_out;
    } out_item_t;

    // Word handed from cell to cell along the divider chain.
    typedef struct packed {
        logic [NUM_CH-1:0][REM_W-1:0] rem;
        logic [NUM_CH-1:0][QUO_W-1:0] quo;
        logic [DIV_W-1:0]             div2;
        logic [7:0]                   luma;
        logic [7:0]                   alpha;
        logic                         last;
    } work_t;

endpackage

`default_nettype wire

// ----- rtl/core/scaled_ycocg_to_bgra_pixel_top.sv -----
// ============================================================================
// scaled_ycocg_to_bgra_pixel_top: scaled YCoCg pixel to BGRA converter
// Turns decoded scaled YCoCg pixels into BGRA items, one per unstalled clock.
// ============================================================================
// The block takes one pixel item per clock when the output side is not held
// off and returns one BGRA item for each, in order. Each color channel is
// Y + 8*k/d with d = chroma_scale + 8, rounded to the nearest integer with
// ties toward positive infinity and clamped to 0..255. The division runs
// through a chain of ten identical cells, one quotient bit per cell, so the
// pipeline is one entry stage, ten divider cells and one output stage. Every
// stage has its own valid flag, so a new item is taken whenever any stage
// ahead has room, even while a finished result still waits on m_ready. The
// alpha_source register picks opaque alpha (0) or the alpha_in field (1); it
// resets to 0 and is meant to be written only while the block is empty.
`default_nettype none

module scaled_ycocg_to_bgra_pixel_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Configuration register write.
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    // Pixel items in.
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sycb_pkg::in_item_t  s_data,
    // BGRA items out.
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sycb_pkg::out_item_t      m_data
);

    localparam int CELLS = sycb_pkg::QUO_W;

    logic alpha_source_reg;

    // Links of the chain: link 0 leaves the entry stage, link CELLS feeds the
    // output stage.
    logic            [CELLS:0] link_valid;
    logic            [CELLS:0] link_ready;
    sycb_pkg::work_t           link_data [CELLS+1];

    // The register is sampled as each item enters; the user must change it only
    // between images, when nothing is in flight; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_source_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            alpha_source_reg <= cfg_wr_data;
        end
    end

    sycb_prep u_prep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .alpha_source (alpha_source_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_data      (s_data),
        .out_valid    (link_valid[0]),
        .out_ready    (link_ready[0]),
        .out_data     (link_data[0])
    );

    // The first cell settles the most significant quotient bit.
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        sycb_div_cell #(
            .BIT_IDX (CELLS - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    sycb_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[CELLS]),
        .in_ready  (link_ready[CELLS]),
        .in_data   (link_data[CELLS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/sycb_prep.sv -----
// ============================================================================
// sycb_prep: entry stage
// Forms the biased numerators and the divisor of the three color channels.
// ============================================================================
`default_nettype none

module sycb_prep (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             alpha_source,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sycb_pkg::in_item_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sycb_pkg::work_t       out_data
);

    logic            valid_reg;
    sycb_pkg::work_t data_reg;
    sycb_pkg::work_t data_next;

    logic signed [9:0]  co;
    logic signed [9:0]  cg;
    logic signed [9:0]  k_blue;
    logic signed [9:0]  k_green;
    logic signed [9:0]  k_red;
    logic        [8:0]  d;
    logic signed [19:0] base;

    // Numerator 16*k + d + 512*d: floor of it over 2*d is the rounded value
    // plus the bias of 256.
    always_comb begin
        co      = signed'({2'b00, in_data.co_byte}) - 10'sd128;
        cg      = signed'({2'b00, in_data.cg_byte}) - 10'sd128;
        k_blue  = -(co + cg);
        k_green = cg;
        k_red   = co - cg;
        d       = {1'b0, in_data.chroma_scale} + 9'd8;
        base    = signed'({2'b00, d, 9'd0}) + signed'({11'd0, d});

        data_next = '0;
        data_next.rem[sycb_pkg::CH_BLUE]  =
            sycb_pkg::REM_W'(base + (20'(k_blue) <<< 4));
        data_next.rem[sycb_pkg::CH_GREEN] =
            sycb_pkg::REM_W'(base + (20'(k_green) <<< 4));
        data_next.rem[sycb_pkg::CH_RED]   =
            sycb_pkg::REM_W'(base + (20'(k_red) <<< 4));
        data_next.div2  = {d, 1'b0};
        data_next.luma  = in_data.luma;
        data_next.alpha = alpha_source ? in_data.alpha_in : sycb_pkg::ALPHA_OPAQUE;
        data_next.last  = in_data.last_pixel;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sycb_div_cell.sv -----
// ============================================================================
// sycb_div_cell: one cell of the divider chain
// Settles one quotient bit of each channel by a restoring compare and subtract.
// ============================================================================
`default_nettype none

module sycb_div_cell #(
    parameter int BIT_IDX = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sycb_pkg::work_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output sycb_pkg::work_t      out_data
);

    logic            valid_reg;
    sycb_pkg::work_t data_reg;
    sycb_pkg::work_t data_next;
    logic [sycb_pkg::CMP_W-1:0] shifted;

    always_comb begin
        shifted   = sycb_pkg::CMP_W'(in_data.div2) << BIT_IDX;
        data_next = in_data;
        for (int ch = 0; ch < sycb_pkg::NUM_CH; ch++) begin
            if (sycb_pkg::CMP_W'(in_data.rem[ch]) >= shifted) begin
                data_next.rem[ch] = in_data.rem[ch] - shifted[sycb_pkg::REM_W-1:0];
                data_next.quo[ch][BIT_IDX] = 1'b1;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sycb_finish.sv -----
// ============================================================================
// sycb_finish: output stage
// Adds luma to each quotient, removes the bias, clamps and holds the result.
// ============================================================================
`default_nettype none

module sycb_finish (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sycb_pkg::work_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sycb_pkg::out_item_t   out_data
);

    localparam int SUM_W = sycb_pkg::QUO_W + 1;

    logic                 valid_reg;
    sycb_pkg::out_item_t  data_reg;
    sycb_pkg::out_item_t  data_next;
    logic [sycb_pkg::NUM_CH-1:0][7:0]       chan;
    logic [sycb_pkg::NUM_CH-1:0][SUM_W-1:0] sum;

    // The value is sum - 256; below the bias it clamps to 0, above 511 to 255.
    always_comb begin
        for (int ch = 0; ch < sycb_pkg::NUM_CH; ch++) begin
            sum[ch] = SUM_W'(in_data.luma) + SUM_W'(in_data.quo[ch]);
            if (sum[ch] < SUM_W'(sycb_pkg::BIAS)) begin
                chan[ch] = 8'd0;
            end else if (sum[ch] >= SUM_W'(2 * sycb_pkg::BIAS)) begin
                chan[ch] = 8'd255;
            end else begin
                chan[ch] = sum[ch][7:0];
            end
        end
        data_next.blue      = chan[sycb_pkg::CH_BLUE];
        data_next.green     = chan[sycb_pkg::CH_GREEN];
        data_next.red       = chan[sycb_pkg::CH_RED];
        data_next.alpha_out = in_data.alpha;
        data_next.last_out  = in_data.last;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire
